// File: src/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg: shared types, constants and a classify function
// Character classes, result layout and field widths for the base64url
// word unpacker.
// ----------------------------------------------------------------------------
package b64u_pkg;

  // fixed field widths
  localparam int CHAR_W  = 8;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 24;
  localparam int DIGIT_W = 6;
  localparam int NEED_W  = 6;
  localparam int SPILL_W = 3;
  localparam int CAUSE_W = 2;

  // default width of the emitted word counter
  localparam int COUNT_BITS_DEF = 24;

  // bits still needed at the start of a word, and bits per digit
  localparam logic [NEED_W-1:0] NEED_FULL  = 6'd32;
  localparam logic [NEED_W-1:0] NEED_DIGIT = 6'd6;

  // end cause codes
  localparam logic [CAUSE_W-1:0] END_NONE  = 2'd0;
  localparam logic [CAUSE_W-1:0] END_LIMIT = 2'd1;
  localparam logic [CAUSE_W-1:0] END_BAD   = 2'd2;

  // character classes
  typedef enum logic [2:0] {
    CLS_DIGIT = 3'b001,
    CLS_SKIP  = 3'b010,
    CLS_BAD   = 3'b100
  } char_class_t;

  typedef struct packed {
    char_class_t         kind;
    logic [DIGIT_W-1:0]  digit;
  } char_info_t;

  // one input transaction
  typedef struct packed {
    logic              restart;
    logic [CHAR_W-1:0] char_in;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [CAUSE_W-1:0] end_cause;
    logic               stream_end;
    logic               word_valid;
    logic [WORD_W-1:0]  data_word;
  } result_t;

  // map a byte onto the url-safe alphabet
  function automatic char_info_t classify(input logic [CHAR_W-1:0] c);
    char_info_t info;
    info.kind  = CLS_BAD;
    info.digit = '0;
    case (c) inside
      [8'h41:8'h5A]: begin
        info.kind  = CLS_DIGIT;
        info.digit = DIGIT_W'(c - 8'h41);
      end
      [8'h61:8'h7A]: begin
        info.kind  = CLS_DIGIT;
        info.digit = DIGIT_W'(c - 8'h61 + 8'd26);
      end
      [8'h30:8'h39]: begin
        info.kind  = CLS_DIGIT;
        info.digit = DIGIT_W'(c - 8'h30 + 8'd52);
      end
      8'h2D: begin
        info.kind  = CLS_DIGIT;
        info.digit = 6'd62;
      end
      8'h5F: begin
        info.kind  = CLS_DIGIT;
        info.digit = 6'd63;
      end
      8'h20, 8'h0A: begin
        info.kind = CLS_SKIP;
      end
      default: begin
        info.kind = CLS_BAD;
      end
    endcase
    return info;
  endfunction

endpackage

// File: src/b64u_pipe_reg.sv
// ----------------------------------------------------------------------------
// b64u_pipe_reg: single register stage with valid/ready
// Holds one transaction; takes a new one whenever it is empty or its
// current one is being taken downstream in the same cycle.
// ----------------------------------------------------------------------------
module b64u_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         full;
  logic [W-1:0] data;

  // free now or freed by the downstream transaction
  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

// File: src/b64u_core.sv
// ----------------------------------------------------------------------------
// b64u_core: decoder state and single-pass update
// Keeps the partial word, bit count, word count, stop flag and word limit,
// and works out the result of one character combinationally.
// ----------------------------------------------------------------------------
module b64u_core #(
  parameter int COUNT_BITS = b64u_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [b64u_pkg::LIMIT_W-1:0]     cfg_limit,
  input  logic                             fire,
  input  b64u_pkg::item_t                  item,
  output logic                             has_result,
  output b64u_pkg::result_t                result
);

  localparam int CMP_W = (COUNT_BITS > b64u_pkg::LIMIT_W) ? COUNT_BITS : b64u_pkg::LIMIT_W;

  logic [b64u_pkg::LIMIT_W-1:0] word_limit;
  logic [b64u_pkg::WORD_W-1:0]  acc, acc_next, eff_acc;
  logic [b64u_pkg::NEED_W-1:0]  need, need_next, eff_need;
  logic [COUNT_BITS-1:0]        count, count_next, eff_count;
  logic                         stopped, stopped_next, eff_stopped;
  logic [b64u_pkg::SPILL_W-1:0] spill;
  logic [b64u_pkg::WORD_W+b64u_pkg::DIGIT_W-1:0] spill_wide;
  b64u_pkg::char_info_t         info;

  // restart clears the state before the byte is looked at
  always_comb begin
    eff_acc     = item.restart ? '0 : acc;
    eff_need    = item.restart ? b64u_pkg::NEED_FULL : need;
    eff_count   = item.restart ? '0 : count;
    eff_stopped = item.restart ? 1'b0 : stopped;
  end

  assign info       = b64u_pkg::classify(item.char_in);
  assign spill      = b64u_pkg::SPILL_W'(b64u_pkg::NEED_DIGIT - eff_need);
  // low spill bits of the digit land at the top of the next word
  assign spill_wide = {info.digit, {b64u_pkg::WORD_W{1'b0}}} >> spill;

  // decode step
  always_comb begin
    acc_next     = eff_acc;
    need_next    = eff_need;
    count_next   = eff_count;
    stopped_next = eff_stopped;
    has_result   = 1'b0;
    result       = '0;
    if (!eff_stopped) begin
      case (info.kind)
        b64u_pkg::CLS_BAD: begin
          stopped_next      = 1'b1;
          has_result        = 1'b1;
          result.stream_end = 1'b1;
          result.end_cause  = b64u_pkg::END_BAD;
        end
        b64u_pkg::CLS_DIGIT: begin
          if (eff_need > b64u_pkg::NEED_DIGIT) begin
            acc_next  = eff_acc
                      | (b64u_pkg::WORD_W'(info.digit) << (eff_need - b64u_pkg::NEED_DIGIT));
            need_next = eff_need - b64u_pkg::NEED_DIGIT;
          end else begin
            acc_next          = spill_wide[b64u_pkg::WORD_W-1:0];
            need_next         = b64u_pkg::NEED_FULL - b64u_pkg::NEED_W'(spill);
            count_next        = eff_count + COUNT_BITS'(1);
            has_result        = 1'b1;
            result.data_word  = eff_acc | (b64u_pkg::WORD_W'(info.digit) >> spill);
            result.word_valid = 1'b1;
            if (word_limit != '0 && CMP_W'(count_next) == CMP_W'(word_limit)) begin
              stopped_next      = 1'b1;
              result.stream_end = 1'b1;
              result.end_cause  = b64u_pkg::END_LIMIT;
            end
          end
        end
        default: begin
          // skipped byte: no change
        end
      endcase
    end
  end

  // word limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit <= '0;
    end else if (cfg_write) begin
      word_limit <= cfg_limit;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      need    <= b64u_pkg::NEED_FULL;
      count   <= '0;
      stopped <= 1'b0;
    end else if (fire) begin
      acc     <= acc_next;
      need    <= need_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

endmodule

// File: src/base64url_word_unpacker.sv
// ----------------------------------------------------------------------------
// base64url_word_unpacker: url-safe base64 to 32-bit word decoder
// Decodes an unpadded base64url character stream, msb first, into words,
// with skipped space and newline, stop on invalid byte and an optional word limit.
//
//   channel   direction  fields
//   s_axis    in         tdata: char_in[7:0]; tuser: restart
//   m_axis    out        tdata: data_word[31:0]; tuser: word_valid, end_cause[1:0];
//                        tlast: stream_end
//   cfg       in         data: word_limit[23:0]
//
// One character per cycle is taken while m_axis does not stall; a result passes
// through the input register, then the result register, to the output.
// The decoder update between the two registers sets the rate: one pass per byte.
// Reset clears the decoder, the word limit and both register stages.
// A stall on m_axis backs up through the output and input registers.
// ----------------------------------------------------------------------------
module base64url_word_unpacker #(
  parameter int COUNT_BITS = b64u_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in[7:0]
  input  logic [0:0]  s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data_word[31:0]
  output logic [2:0]  m_axis_tuser,   // word_valid, end_cause[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data        // word_limit[23:0]
);

  localparam int ITEM_W = $bits(b64u_pkg::item_t);
  localparam int RES_W  = $bits(b64u_pkg::result_t);

  b64u_pkg::item_t   in_item, held_item;
  b64u_pkg::result_t result, out_result;
  logic              held_valid, core_ready, has_result, fire;

  assign cfg_ready = 1'b1;

  assign in_item.char_in = s_axis_tdata;
  assign in_item.restart = s_axis_tuser[0];

  // input register
  b64u_pipe_reg #(.W(ITEM_W)) u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_item),
    .out_valid (held_valid),
    .out_ready (core_ready),
    .out_data  (held_item)
  );

  // a held character is consumed whenever the result register can take it
  assign fire = held_valid && core_ready;

  b64u_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_limit  (cfg_data),
    .fire       (fire),
    .item       (held_item),
    .has_result (has_result),
    .result     (result)
  );

  // result register
  b64u_pipe_reg #(.W(RES_W)) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (held_valid && has_result),
    .in_ready  (core_ready),
    .in_data   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = out_result.data_word;
  assign m_axis_tuser = {out_result.end_cause, out_result.word_valid};
  assign m_axis_tlast = out_result.stream_end;

endmodule
